// ===== hdl/hxc_pkg.sv =====
// Shared types, constants and the composition micro-program of the transform composer.
// Depends on nothing; hxc_ctrl, hxc_dp and the top level import it.
package hxc_pkg;

  localparam int MAX_BONES = 256;
  localparam int AddrW = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;

  localparam int ProgLen = 44;
  localparam int SqrtSteps = 31;
  localparam int DivSteps = 15;

  // Element 0 of q is w; elements 0..2 of p and s are x, y, z.
  typedef struct packed {
    logic [3:0][15:0] q;
    logic [2:0][31:0] p;
    logic [2:0][31:0] s;
  } xf_t;

  localparam int XfW = $bits(xf_t);

  typedef enum logic [4:0] {
    SRC_ZERO,
    SRC_PQW, SRC_PQX, SRC_PQY, SRC_PQZ,
    SRC_LQW, SRC_LQX, SRC_LQY, SRC_LQZ,
    SRC_PS0, SRC_PS1, SRC_PS2,
    SRC_LS0, SRC_LS1, SRC_LS2,
    SRC_LP0, SRC_LP1, SRC_LP2,
    SRC_M0, SRC_M1, SRC_M2, SRC_M3,
    SRC_V0, SRC_V1, SRC_V2,
    SRC_UV0, SRC_UV1, SRC_UV2,
    SRC_K
  } src_e;

  typedef enum logic [2:0] {
    ACC_NOP, ACC_LD, ACC_ADD, ACC_SUB, ACC_ADD2, ACC_SUB2
  } acc_op_e;

  typedef enum logic [4:0] {
    WB_NONE,
    WB_C0, WB_C1, WB_C2, WB_C3,
    WB_SUM,
    WB_WS0, WB_WS1, WB_WS2,
    WB_V0, WB_V1, WB_V2,
    WB_UV0, WB_UV1, WB_UV2,
    WB_P0, WB_P1, WB_P2
  } wb_e;

  typedef struct packed {
    src_e    a;
    src_e    b;
    acc_op_e op;
    wb_e     wb;
  } uop_t;

  localparam uop_t UopNop = '{SRC_ZERO, SRC_ZERO, ACC_NOP, WB_NONE};

  typedef struct packed {
    logic load_in;
    logic ram_rd;
    uop_t uop;
    logic sqrt_start;
    logic sqrt_step;
    logic div_start;
    logic div_step;
    logic finish;
  } hxc_cmd_t;

  typedef struct packed {
    logic root;
  } hxc_sts_t;

  // One multiply-accumulate per step; a destination is not read until the step that writes it
  // has passed the product, accumulator and write-back registers.
  function automatic uop_t uprog(input logic [5:0] step);
    uop_t u;
    u = UopNop;
    case (step)
      6'd0:  u = '{SRC_PQW, SRC_LQW, ACC_LD,   WB_NONE};
      6'd1:  u = '{SRC_PQX, SRC_LQX, ACC_SUB,  WB_NONE};
      6'd2:  u = '{SRC_PQY, SRC_LQY, ACC_SUB,  WB_NONE};
      6'd3:  u = '{SRC_PQZ, SRC_LQZ, ACC_SUB,  WB_C0};
      6'd4:  u = '{SRC_PQW, SRC_LQX, ACC_LD,   WB_NONE};
      6'd5:  u = '{SRC_PQX, SRC_LQW, ACC_ADD,  WB_NONE};
      6'd6:  u = '{SRC_PQY, SRC_LQZ, ACC_ADD,  WB_NONE};
      6'd7:  u = '{SRC_PQZ, SRC_LQY, ACC_SUB,  WB_C1};
      6'd8:  u = '{SRC_PQW, SRC_LQY, ACC_LD,   WB_NONE};
      6'd9:  u = '{SRC_PQX, SRC_LQZ, ACC_SUB,  WB_NONE};
      6'd10: u = '{SRC_PQY, SRC_LQW, ACC_ADD,  WB_NONE};
      6'd11: u = '{SRC_PQZ, SRC_LQX, ACC_ADD,  WB_C2};
      6'd12: u = '{SRC_PQW, SRC_LQZ, ACC_LD,   WB_NONE};
      6'd13: u = '{SRC_PQX, SRC_LQY, ACC_ADD,  WB_NONE};
      6'd14: u = '{SRC_PQY, SRC_LQX, ACC_SUB,  WB_NONE};
      6'd15: u = '{SRC_PQZ, SRC_LQW, ACC_ADD,  WB_C3};
      6'd16: u = '{SRC_PS0, SRC_LS0, ACC_LD,   WB_WS0};
      6'd17: u = '{SRC_PS1, SRC_LS1, ACC_LD,   WB_WS1};
      6'd18: u = '{SRC_PS2, SRC_LS2, ACC_LD,   WB_WS2};
      6'd19: u = '{SRC_PS0, SRC_LP0, ACC_LD,   WB_V0};
      6'd20: u = '{SRC_PS1, SRC_LP1, ACC_LD,   WB_V1};
      6'd21: u = '{SRC_PS2, SRC_LP2, ACC_LD,   WB_V2};
      6'd22: u = '{SRC_M0,  SRC_M0,  ACC_LD,   WB_NONE};
      6'd23: u = '{SRC_M1,  SRC_M1,  ACC_ADD,  WB_NONE};
      6'd24: u = '{SRC_M2,  SRC_M2,  ACC_ADD,  WB_NONE};
      6'd25: u = '{SRC_M3,  SRC_M3,  ACC_ADD,  WB_SUM};
      6'd26: u = '{SRC_PQY, SRC_V2,  ACC_LD,   WB_NONE};
      6'd27: u = '{SRC_PQZ, SRC_V1,  ACC_SUB,  WB_UV0};
      6'd28: u = '{SRC_PQZ, SRC_V0,  ACC_LD,   WB_NONE};
      6'd29: u = '{SRC_PQX, SRC_V2,  ACC_SUB,  WB_UV1};
      6'd30: u = '{SRC_PQX, SRC_V1,  ACC_LD,   WB_NONE};
      6'd31: u = '{SRC_PQY, SRC_V0,  ACC_SUB,  WB_UV2};
      6'd32: u = '{SRC_V0,  SRC_K,   ACC_LD,   WB_NONE};
      6'd33: u = '{SRC_PQW, SRC_UV0, ACC_ADD2, WB_NONE};
      6'd34: u = '{SRC_PQY, SRC_UV2, ACC_ADD2, WB_NONE};
      6'd35: u = '{SRC_PQZ, SRC_UV1, ACC_SUB2, WB_P0};
      6'd36: u = '{SRC_V1,  SRC_K,   ACC_LD,   WB_NONE};
      6'd37: u = '{SRC_PQW, SRC_UV1, ACC_ADD2, WB_NONE};
      6'd38: u = '{SRC_PQZ, SRC_UV0, ACC_ADD2, WB_NONE};
      6'd39: u = '{SRC_PQX, SRC_UV2, ACC_SUB2, WB_P1};
      6'd40: u = '{SRC_V2,  SRC_K,   ACC_LD,   WB_NONE};
      6'd41: u = '{SRC_PQW, SRC_UV2, ACC_ADD2, WB_NONE};
      6'd42: u = '{SRC_PQX, SRC_UV1, ACC_ADD2, WB_NONE};
      6'd43: u = '{SRC_PQY, SRC_UV0, ACC_SUB2, WB_P2};
      default: u = UopNop;
    endcase
    return u;
  endfunction

endpackage

// ===== hdl/hxc_if.sv =====
// Item channels of the transform composer: bone in, derived transform out.
// Stand-alone; no package needed.
interface hxc_in_if;
  logic               valid;
  logic               ready;
  logic [7:0]         bone_index;
  logic [8:0]         parent_index;
  logic signed [15:0] local_orient_w;
  logic signed [15:0] local_orient_x;
  logic signed [15:0] local_orient_y;
  logic signed [15:0] local_orient_z;
  logic signed [31:0] local_pos_x;
  logic signed [31:0] local_pos_y;
  logic signed [31:0] local_pos_z;
  logic signed [31:0] local_scale_x;
  logic signed [31:0] local_scale_y;
  logic signed [31:0] local_scale_z;

  modport source (
    output valid, bone_index, parent_index, local_orient_w, local_orient_x, local_orient_y,
           local_orient_z, local_pos_x, local_pos_y, local_pos_z, local_scale_x,
           local_scale_y, local_scale_z,
    input  ready
  );
  modport sink (
    input  valid, bone_index, parent_index, local_orient_w, local_orient_x, local_orient_y,
           local_orient_z, local_pos_x, local_pos_y, local_pos_z, local_scale_x,
           local_scale_y, local_scale_z,
    output ready
  );
endinterface

interface hxc_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         done_bone_index;
  logic signed [15:0] world_orient_w;
  logic signed [15:0] world_orient_x;
  logic signed [15:0] world_orient_y;
  logic signed [15:0] world_orient_z;
  logic signed [31:0] world_pos_x;
  logic signed [31:0] world_pos_y;
  logic signed [31:0] world_pos_z;
  logic signed [31:0] world_scale_x;
  logic signed [31:0] world_scale_y;
  logic signed [31:0] world_scale_z;

  modport source (
    output valid, done_bone_index, world_orient_w, world_orient_x, world_orient_y,
           world_orient_z, world_pos_x, world_pos_y, world_pos_z, world_scale_x,
           world_scale_y, world_scale_z,
    input  ready
  );
  modport sink (
    input  valid, done_bone_index, world_orient_w, world_orient_x, world_orient_y,
           world_orient_z, world_pos_x, world_pos_y, world_pos_z, world_scale_x,
           world_scale_y, world_scale_z,
    output ready
  );
endinterface

// ===== hdl/hierarchical_transform_compose.sv =====
// Top level of the hierarchical bone transform composer.
// Depends on hxc_pkg, hxc_if, hxc_ctrl and hxc_dp.
// A root bone's transform passes straight to the result; any other bone goes through
// the 44-step multiply-accumulate program, 31 square root steps and 15 divider steps.
// One item is in work at a time: a new bone is accepted only after the last one has finished.
// Reset clears the controller and the result valid flag; the transform RAM is not cleared.
module hierarchical_transform_compose import hxc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  hxc_in_if.sink     in_i,
  hxc_out_if.source  out_o
);

  hxc_cmd_t   cmd;
  hxc_sts_t   sts;
  xf_t        in_xf;
  xf_t        out_xf;
  logic [7:0] out_bone;

  assign in_xf.q[0] = in_i.local_orient_w;
  assign in_xf.q[1] = in_i.local_orient_x;
  assign in_xf.q[2] = in_i.local_orient_y;
  assign in_xf.q[3] = in_i.local_orient_z;
  assign in_xf.p[0] = in_i.local_pos_x;
  assign in_xf.p[1] = in_i.local_pos_y;
  assign in_xf.p[2] = in_i.local_pos_z;
  assign in_xf.s[0] = in_i.local_scale_x;
  assign in_xf.s[1] = in_i.local_scale_y;
  assign in_xf.s[2] = in_i.local_scale_z;

  hxc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  hxc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_bone_i   (in_i.bone_index),
    .in_parent_i (in_i.parent_index),
    .in_xf_i     (in_xf),
    .out_bone_o  (out_bone),
    .out_xf_o    (out_xf)
  );

  assign out_o.done_bone_index = out_bone;
  assign out_o.world_orient_w = out_xf.q[0];
  assign out_o.world_orient_x = out_xf.q[1];
  assign out_o.world_orient_y = out_xf.q[2];
  assign out_o.world_orient_z = out_xf.q[3];
  assign out_o.world_pos_x = out_xf.p[0];
  assign out_o.world_pos_y = out_xf.p[1];
  assign out_o.world_pos_z = out_xf.p[2];
  assign out_o.world_scale_x = out_xf.s[0];
  assign out_o.world_scale_y = out_xf.s[1];
  assign out_o.world_scale_z = out_xf.s[2];

endmodule

// ===== hdl/hxc_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module hxc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/hxc_ctrl.sv =====
// Sequencing state machine of the transform composer: drives the datapath commands.
// Depends on hxc_pkg.
module hxc_ctrl import hxc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     out_ready_i,
  output logic     out_valid_o,
  input  hxc_sts_t sts_i,
  output hxc_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_PROG, ST_SQINIT, ST_SQRT, ST_DVINIT, ST_DIV, ST_DONE
  } state_e;

  state_e     state_q;
  logic [5:0] cnt_q;
  logic       out_valid_q;
  logic       can_finish;

  assign in_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign can_finish = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    cmd_o = '0;
    cmd_o.uop = UopNop;
    cmd_o.load_in = in_valid_i && (state_q == ST_IDLE);
    cmd_o.ram_rd = (state_q == ST_READ);
    if (state_q == ST_PROG) begin
      cmd_o.uop = uprog(cnt_q);
    end
    cmd_o.sqrt_start = (state_q == ST_SQINIT);
    cmd_o.sqrt_step = (state_q == ST_SQRT);
    cmd_o.div_start = (state_q == ST_DVINIT);
    cmd_o.div_step = (state_q == ST_DIV);
    cmd_o.finish = can_finish;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (can_finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_READ;
          end
        end
        ST_READ: begin
          cnt_q <= '0;
          state_q <= sts_i.root ? ST_DONE : ST_PROG;
        end
        ST_PROG: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'(ProgLen - 1)) begin
            state_q <= ST_SQINIT;
          end
        end
        ST_SQINIT: begin
          cnt_q <= '0;
          state_q <= ST_SQRT;
        end
        ST_SQRT: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'(SqrtSteps - 1)) begin
            state_q <= ST_DVINIT;
          end
        end
        ST_DVINIT: begin
          cnt_q <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'(DivSteps - 1)) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (can_finish) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/hxc_dp.sv =====
// Datapath of the transform composer: shared multiply-accumulate unit, square root,
// four divider lanes, the derived transform RAM and the result register.
// Depends on hxc_pkg and hxc_ram.
module hxc_dp import hxc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  hxc_cmd_t cmd_i,
  output hxc_sts_t sts_o,
  input  logic [7:0] in_bone_i,
  input  logic [8:0] in_parent_i,
  input  xf_t      in_xf_i,
  output logic [7:0] out_bone_o,
  output xf_t      out_xf_o
);

  function automatic logic signed [63:0] rnd(input logic signed [63:0] x, input int sh);
    logic [63:0] mag;
    logic [63:0] r;
    mag = x[63] ? 64'(-x) : 64'(x);
    r = (mag + (64'd1 << (sh - 1))) >> sh;
    return x[63] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic [31:0] sat32(input logic signed [63:0] x);
    logic [31:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (x < -64'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  logic [7:0]  bone_q;
  logic [8:0]  parent_q;
  xf_t         loc_q;
  xf_t         par;
  xf_t         world;
  logic [7:0]  out_bone_q;
  xf_t         out_xf_q;

  logic signed [34:0] c_q [4];
  logic [28:0]        m [4];
  logic [61:0]        sum_q;
  logic [31:0]        ws_q [3];
  logic [31:0]        v_q [3];
  logic signed [34:0] uv_q [3];
  logic [31:0]        p_q [3];

  logic signed [35:0] opa;
  logic signed [35:0] opb;
  logic signed [71:0] prod;
  logic signed [63:0] prod_q;
  logic signed [63:0] acc_q;
  acc_op_e            op1_q;
  wb_e                wb1_q;
  wb_e                wb2_q;

  logic [61:0] sq_v_q;
  logic [33:0] sq_rem_q;
  logic [30:0] sq_root_q;
  logic [33:0] sq_rem_s;
  logic [33:0] sq_trial;

  logic [45:0] dv_rem_q [4];
  logic [14:0] dv_quo_q [4];
  logic [45:0] dv_dsh_q;

  logic store;

  assign sts_o.root = (int'(parent_q) >= MAX_BONES);
  assign store = (int'(bone_q) < MAX_BONES);

  hxc_ram #(
    .Width (XfW),
    .Depth (MAX_BONES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.finish && store),
    .waddr_i (AddrW'(bone_q)),
    .wdata_i (world),
    .re_i    (cmd_i.ram_rd),
    .raddr_i (AddrW'(parent_q)),
    .rdata_o (par)
  );

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      m[i] = c_q[i][34] ? 29'((-c_q[i]) >>> 4) : 29'(c_q[i] >>> 4);
    end
  end

  function automatic logic signed [35:0] pick(input src_e s, input xf_t pr, input xf_t lc,
                                              input logic [28:0] mm [4],
                                              input logic [31:0] vv [3],
                                              input logic signed [34:0] uu [3]);
    logic signed [35:0] r;
    case (s)
      SRC_PQW: r = 36'($signed(pr.q[0]));
      SRC_PQX: r = 36'($signed(pr.q[1]));
      SRC_PQY: r = 36'($signed(pr.q[2]));
      SRC_PQZ: r = 36'($signed(pr.q[3]));
      SRC_LQW: r = 36'($signed(lc.q[0]));
      SRC_LQX: r = 36'($signed(lc.q[1]));
      SRC_LQY: r = 36'($signed(lc.q[2]));
      SRC_LQZ: r = 36'($signed(lc.q[3]));
      SRC_PS0: r = 36'($signed(pr.s[0]));
      SRC_PS1: r = 36'($signed(pr.s[1]));
      SRC_PS2: r = 36'($signed(pr.s[2]));
      SRC_LS0: r = 36'($signed(lc.s[0]));
      SRC_LS1: r = 36'($signed(lc.s[1]));
      SRC_LS2: r = 36'($signed(lc.s[2]));
      SRC_LP0: r = 36'($signed(lc.p[0]));
      SRC_LP1: r = 36'($signed(lc.p[1]));
      SRC_LP2: r = 36'($signed(lc.p[2]));
      SRC_M0:  r = $signed({7'b0, mm[0]});
      SRC_M1:  r = $signed({7'b0, mm[1]});
      SRC_M2:  r = $signed({7'b0, mm[2]});
      SRC_M3:  r = $signed({7'b0, mm[3]});
      SRC_V0:  r = 36'($signed(vv[0]));
      SRC_V1:  r = 36'($signed(vv[1]));
      SRC_V2:  r = 36'($signed(vv[2]));
      SRC_UV0: r = 36'(uu[0]);
      SRC_UV1: r = 36'(uu[1]);
      SRC_UV2: r = 36'(uu[2]);
      SRC_K:   r = 36'sd16384;
      default: r = '0;
    endcase
    return r;
  endfunction

  assign opa = pick(cmd_i.uop.a, par, loc_q, m, v_q, uv_q);
  assign opb = pick(cmd_i.uop.b, par, loc_q, m, v_q, uv_q);
  assign prod = opa * opb;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op1_q <= ACC_NOP;
      wb1_q <= WB_NONE;
      wb2_q <= WB_NONE;
    end else begin
      op1_q <= cmd_i.uop.op;
      wb1_q <= cmd_i.uop.wb;
      wb2_q <= wb1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod[63:0];
    case (op1_q)
      ACC_LD:   acc_q <= prod_q;
      ACC_ADD:  acc_q <= acc_q + prod_q;
      ACC_SUB:  acc_q <= acc_q - prod_q;
      ACC_ADD2: acc_q <= acc_q + (prod_q <<< 1);
      ACC_SUB2: acc_q <= acc_q - (prod_q <<< 1);
      default:  acc_q <= acc_q;
    endcase
    case (wb2_q)
      WB_C0:  c_q[0] <= acc_q[34:0];
      WB_C1:  c_q[1] <= acc_q[34:0];
      WB_C2:  c_q[2] <= acc_q[34:0];
      WB_C3:  c_q[3] <= acc_q[34:0];
      WB_SUM: sum_q <= acc_q[61:0];
      WB_WS0: ws_q[0] <= sat32(rnd(acc_q, 16));
      WB_WS1: ws_q[1] <= sat32(rnd(acc_q, 16));
      WB_WS2: ws_q[2] <= sat32(rnd(acc_q, 16));
      WB_V0:  v_q[0] <= sat32(rnd(acc_q, 16));
      WB_V1:  v_q[1] <= sat32(rnd(acc_q, 16));
      WB_V2:  v_q[2] <= sat32(rnd(acc_q, 16));
      WB_UV0: uv_q[0] <= 35'(rnd(acc_q, 14));
      WB_UV1: uv_q[1] <= 35'(rnd(acc_q, 14));
      WB_UV2: uv_q[2] <= 35'(rnd(acc_q, 14));
      WB_P0:  p_q[0] <= sat32(rnd(acc_q, 14) + 64'($signed(par.p[0])));
      WB_P1:  p_q[1] <= sat32(rnd(acc_q, 14) + 64'($signed(par.p[1])));
      WB_P2:  p_q[2] <= sat32(rnd(acc_q, 14) + 64'($signed(par.p[2])));
      default: ;
    endcase
  end

  // Square root takes two radicand bits per step; each divider lane yields one quotient bit.
  assign sq_rem_s = {sq_rem_q[31:0], sq_v_q[61:60]};
  assign sq_trial = {1'b0, sq_root_q, 2'b01};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      bone_q <= in_bone_i;
      parent_q <= in_parent_i;
      loc_q <= in_xf_i;
    end
    if (cmd_i.sqrt_start) begin
      sq_v_q <= sum_q;
      sq_rem_q <= '0;
      sq_root_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      sq_v_q <= sq_v_q << 2;
      if (sq_rem_s >= sq_trial) begin
        sq_rem_q <= sq_rem_s - sq_trial;
        sq_root_q <= {sq_root_q[29:0], 1'b1};
      end else begin
        sq_rem_q <= sq_rem_s;
        sq_root_q <= {sq_root_q[29:0], 1'b0};
      end
    end
    if (cmd_i.div_start) begin
      dv_dsh_q <= 46'({sq_root_q, 15'b0});
      for (int i = 0; i < 4; i++) begin
        dv_rem_q[i] <= 46'({m[i], 15'b0}) + 46'(sq_root_q);
        dv_quo_q[i] <= '0;
      end
    end else if (cmd_i.div_step) begin
      dv_dsh_q <= dv_dsh_q >> 1;
      for (int i = 0; i < 4; i++) begin
        if (dv_rem_q[i] >= dv_dsh_q) begin
          dv_rem_q[i] <= dv_rem_q[i] - dv_dsh_q;
          dv_quo_q[i] <= {dv_quo_q[i][13:0], 1'b1};
        end else begin
          dv_quo_q[i] <= {dv_quo_q[i][13:0], 1'b0};
        end
      end
    end
    if (cmd_i.finish) begin
      out_bone_q <= bone_q;
      out_xf_q <= world;
    end
  end

  always_comb begin
    if (sts_o.root) begin
      world = loc_q;
    end else begin
      for (int i = 0; i < 4; i++) begin
        if (sq_root_q == '0) begin
          world.q[i] = (i == 0) ? 16'd16384 : 16'd0;
        end else if (c_q[i][34]) begin
          world.q[i] = -{1'b0, dv_quo_q[i]};
        end else begin
          world.q[i] = {1'b0, dv_quo_q[i]};
        end
      end
      for (int i = 0; i < 3; i++) begin
        world.p[i] = p_q[i];
        world.s[i] = ws_q[i];
      end
    end
  end

  assign out_bone_o = out_bone_q;
  assign out_xf_o = out_xf_q;

endmodule
